/* rtl/dgafp_pkg.sv */
`timescale 1ns / 1ps

package dgafp_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CH_Y_START = 8'h59;
    localparam logic [7:0] CH_B_START = 8'h42;
    localparam logic [7:0] CH_Y_END   = 8'h79;
    localparam logic [7:0] CH_B_END   = 8'h62;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic signed [FIELD_W-1:0] NO_GOAL_RESET = -16'sd74;

    typedef enum logic {
        REG_ATTACK_YELLOW = 1'b0,
        REG_NO_GOAL_CODE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        COLOUR_YELLOW = 1'b0,
        COLOUR_BLUE   = 1'b1
    } colour_t;

    typedef struct packed {
        logic       y_start;
        logic       b_start;
        logic       y_end;
        logic       b_end;
        logic       minus;
        logic       digit_en;
        logic [3:0] digit;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        logic [7:0]  d;
        d          = b - CH_ZERO;
        c.y_start  = (b == CH_Y_START);
        c.b_start  = (b == CH_B_START);
        c.y_end    = (b == CH_Y_END);
        c.b_end    = (b == CH_B_END);
        c.minus    = (b == CH_MINUS);
        c.digit_en = (b >= CH_ZERO) && (b <= CH_NINE);
        c.digit    = d[3:0];
        return c;
    endfunction

endpackage

/* rtl/dgafp_front.sv */
`timescale 1ns / 1ps

module dgafp_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    output logic                     f_valid,
    input  logic                     f_ready,
    output dgafp_pkg::byte_class_t   f_item
);

    logic                   valid_reg, valid_next;
    dgafp_pkg::byte_class_t item_reg, item_next;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next = dgafp_pkg::classify(s_rx_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

/* rtl/dgafp_queue.sv */
`timescale 1ns / 1ps

module dgafp_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  dgafp_pkg::byte_class_t   push_item,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output dgafp_pkg::byte_class_t   pop_item
);

    localparam int PTR_W = (dgafp_pkg::QUEUE_DEPTH > 1) ? $clog2(dgafp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(dgafp_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dgafp_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(dgafp_pkg::QUEUE_DEPTH);

    dgafp_pkg::byte_class_t mem [dgafp_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/dgafp_back.sv */
`timescale 1ns / 1ps

module dgafp_back #(
    parameter int VALUE_WIDTH = dgafp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_attack_yellow,
    input  logic signed [dgafp_pkg::FIELD_W-1:0]   cfg_no_goal_code,
    input  logic                                   q_valid,
    output logic                                   q_ready,
    input  dgafp_pkg::byte_class_t                 q_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_frame_colour,
    output logic signed [dgafp_pkg::FIELD_W-1:0]   m_raw_value,
    output logic signed [dgafp_pkg::FIELD_W-1:0]   m_held_yellow,
    output logic signed [dgafp_pkg::FIELD_W-1:0]   m_held_blue,
    output logic                                   m_pair_ready,
    output logic signed [dgafp_pkg::FIELD_W-1:0]   m_attack_angle,
    output logic signed [dgafp_pkg::FIELD_W-1:0]   m_defense_angle
);

    localparam int FW    = dgafp_pkg::FIELD_W;
    localparam int ACC_W = VALUE_WIDTH - 1;
    localparam int SUM_W = ACC_W + 4;
    localparam int CMP_W = (VALUE_WIDTH > FW) ? VALUE_WIDTH : FW;
    localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_W{1'b1}});

    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(acc) * SUM_W'(10) + SUM_W'(digit);
        return (sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
    endfunction

    function automatic logic signed [FW-1:0] to_field(input logic signed [VALUE_WIDTH-1:0] v);
        logic signed [CMP_W-1:0] w;
        w = CMP_W'(v);
        return w[FW-1:0];
    endfunction

    // parser state
    logic                          y_started_reg, y_started_next;
    logic                          y_ended_reg, y_ended_next;
    logic                          y_minus_reg, y_minus_next;
    logic [ACC_W-1:0]              y_acc_reg, y_acc_next;
    logic                          b_started_reg, b_started_next;
    logic                          b_ended_reg, b_ended_next;
    logic                          b_minus_reg, b_minus_next;
    logic [ACC_W-1:0]              b_acc_reg, b_acc_next;
    logic signed [VALUE_WIDTH-1:0] last_y_reg, last_y_next;
    logic signed [VALUE_WIDTH-1:0] last_b_reg, last_b_next;
    logic [1:0]                    frames_reg, frames_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_colour_reg, out_colour_next;
    logic signed [FW-1:0] out_raw_reg, out_raw_next;
    logic signed [FW-1:0] out_held_y_reg, out_held_y_next;
    logic signed [FW-1:0] out_held_b_reg, out_held_b_next;
    logic                 out_pair_reg, out_pair_next;
    logic signed [FW-1:0] out_atk_reg, out_atk_next;
    logic signed [FW-1:0] out_def_reg, out_def_next;

    logic                          take;
    logic                          ys, ye, bs, be, y_feed, b_feed;
    logic [ACC_W-1:0]              y_acc_fed, b_acc_fed, sel_acc;
    logic                          y_minus_fed, b_minus_fed, sel_minus;
    logic                          y_close, b_close, closed, pair;
    logic signed [VALUE_WIDTH-1:0] acc_val, raw;
    logic                          raw_is_no_goal;
    logic signed [VALUE_WIDTH-1:0] last_y_new, last_b_new, atk, dfd;
    logic [1:0]                    frames_inc;

    assign q_ready = !out_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    always_comb begin
        ys     = y_started_reg | q_item.y_start;
        ye     = y_ended_reg | q_item.y_end;
        bs     = b_started_reg | q_item.b_start;
        be     = b_ended_reg | q_item.b_end;
        y_feed = ys && !ye;
        b_feed = bs && !be;

        y_acc_fed   = (y_feed && q_item.digit_en) ? add_digit(y_acc_reg, q_item.digit) : y_acc_reg;
        b_acc_fed   = (b_feed && q_item.digit_en) ? add_digit(b_acc_reg, q_item.digit) : b_acc_reg;
        y_minus_fed = y_minus_reg | (y_feed && q_item.minus);
        b_minus_fed = b_minus_reg | (b_feed && q_item.minus);

        y_close = ys && ye;
        b_close = !y_close && bs && be;
        closed  = y_close || b_close;

        sel_acc   = y_close ? y_acc_fed : b_acc_fed;
        sel_minus = y_close ? y_minus_fed : b_minus_fed;
        acc_val   = signed'({1'b0, sel_acc});
        raw       = sel_minus ? -acc_val : acc_val;

        raw_is_no_goal = (CMP_W'(raw) == CMP_W'(cfg_no_goal_code));
        last_y_new     = (y_close && !raw_is_no_goal) ? raw : last_y_reg;
        last_b_new     = (b_close && !raw_is_no_goal) ? raw : last_b_reg;

        frames_inc = frames_reg + 2'd1;
        pair       = closed && frames_inc[1];
        atk        = '0;
        dfd        = '0;
        if (pair) begin
            atk = cfg_attack_yellow ? last_y_new : last_b_new;
            dfd = cfg_attack_yellow ? -last_b_new : -last_y_new;
        end
    end

    always_comb begin
        y_started_next = y_started_reg;
        y_ended_next   = y_ended_reg;
        y_minus_next   = y_minus_reg;
        y_acc_next     = y_acc_reg;
        b_started_next = b_started_reg;
        b_ended_next   = b_ended_reg;
        b_minus_next   = b_minus_reg;
        b_acc_next     = b_acc_reg;
        last_y_next    = last_y_reg;
        last_b_next    = last_b_reg;
        frames_next    = frames_reg;

        out_valid_next  = out_valid_reg;
        out_colour_next = out_colour_reg;
        out_raw_next    = out_raw_reg;
        out_held_y_next = out_held_y_reg;
        out_held_b_next = out_held_b_reg;
        out_pair_next   = out_pair_reg;
        out_atk_next    = out_atk_reg;
        out_def_next    = out_def_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (take) begin
            if (y_close) begin
                y_started_next = 1'b0;
                y_ended_next   = 1'b0;
                y_minus_next   = 1'b0;
                y_acc_next     = '0;
            end else begin
                y_started_next = ys;
                y_ended_next   = ye;
                y_minus_next   = y_minus_fed;
                y_acc_next     = y_acc_fed;
            end
            if (b_close) begin
                b_started_next = 1'b0;
                b_ended_next   = 1'b0;
                b_minus_next   = 1'b0;
                b_acc_next     = '0;
            end else begin
                b_started_next = bs;
                b_ended_next   = be;
                b_minus_next   = b_minus_fed;
                b_acc_next     = b_acc_fed;
            end
            last_y_next = last_y_new;
            last_b_next = last_b_new;

            if (closed) begin
                frames_next     = pair ? 2'd0 : frames_inc;
                out_valid_next  = 1'b1;
                out_colour_next = b_close ? dgafp_pkg::COLOUR_BLUE : dgafp_pkg::COLOUR_YELLOW;
                out_raw_next    = to_field(raw);
                out_held_y_next = to_field(last_y_new);
                out_held_b_next = to_field(last_b_new);
                out_pair_next   = pair;
                out_atk_next    = to_field(atk);
                out_def_next    = to_field(dfd);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_started_reg <= 1'b0;
            y_ended_reg   <= 1'b0;
            y_minus_reg   <= 1'b0;
            y_acc_reg     <= '0;
            b_started_reg <= 1'b0;
            b_ended_reg   <= 1'b0;
            b_minus_reg   <= 1'b0;
            b_acc_reg     <= '0;
            last_y_reg    <= '0;
            last_b_reg    <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            y_started_reg <= y_started_next;
            y_ended_reg   <= y_ended_next;
            y_minus_reg   <= y_minus_next;
            y_acc_reg     <= y_acc_next;
            b_started_reg <= b_started_next;
            b_ended_reg   <= b_ended_next;
            b_minus_reg   <= b_minus_next;
            b_acc_reg     <= b_acc_next;
            last_y_reg    <= last_y_next;
            last_b_reg    <= last_b_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_colour_reg <= out_colour_next;
        out_raw_reg    <= out_raw_next;
        out_held_y_reg <= out_held_y_next;
        out_held_b_reg <= out_held_b_next;
        out_pair_reg   <= out_pair_next;
        out_atk_reg    <= out_atk_next;
        out_def_reg    <= out_def_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_colour  = out_colour_reg;
    assign m_raw_value     = out_raw_reg;
    assign m_held_yellow   = out_held_y_reg;
    assign m_held_blue     = out_held_b_reg;
    assign m_pair_ready    = out_pair_reg;
    assign m_attack_angle  = out_atk_reg;
    assign m_defense_angle = out_def_reg;

endmodule

/* rtl/dual_goal_angle_frame_parser_unit.sv */
`timescale 1ns / 1ps

// Parses the camera byte stream into yellow ('Y'..'y') and blue ('B'..'b') goal angles,
// one byte per cycle sustained with no bubbles while the result output is not stalled.
// A byte passes a classify register, a two-beat queue and the parser stage, whose
// combinational saturating multiply-by-ten accumulate sets the one-byte-per-cycle rate;
// a closing letter's result beat is registered. Every closed frame gives one result
// beat, and every second one also carries the attack and defense angles (pair_ready).
// Registers: attack_yellow at byte address 0, no_goal_code at byte address 4.
module dual_goal_angle_frame_parser_unit #(
    parameter int VALUE_WIDTH = dgafp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [dgafp_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [dgafp_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [dgafp_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                     pready,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [7:0]                               s_rx_byte,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_frame_colour,
    output logic signed [dgafp_pkg::FIELD_W-1:0]     m_raw_value,
    output logic signed [dgafp_pkg::FIELD_W-1:0]     m_held_yellow,
    output logic signed [dgafp_pkg::FIELD_W-1:0]     m_held_blue,
    output logic                                     m_pair_ready,
    output logic signed [dgafp_pkg::FIELD_W-1:0]     m_attack_angle,
    output logic signed [dgafp_pkg::FIELD_W-1:0]     m_defense_angle
);

    localparam int FW = dgafp_pkg::FIELD_W;
    localparam int DW = dgafp_pkg::CFG_DATA_W;

    logic                 attack_yellow_reg, attack_yellow_next;
    logic signed [FW-1:0] no_goal_reg, no_goal_next;
    dgafp_pkg::cfg_reg_t  reg_sel;
    logic                 cfg_write;

    logic                   f_valid, f_ready;
    dgafp_pkg::byte_class_t f_item;
    logic                   q_valid, q_ready;
    dgafp_pkg::byte_class_t q_item;
    logic                   q_pop;

    // config port
    assign pready    = 1'b1;
    assign reg_sel   = dgafp_pkg::cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            dgafp_pkg::REG_ATTACK_YELLOW: prdata = DW'(attack_yellow_reg);
            dgafp_pkg::REG_NO_GOAL_CODE:  prdata = DW'(no_goal_reg);
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        attack_yellow_next = attack_yellow_reg;
        no_goal_next       = no_goal_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                dgafp_pkg::REG_ATTACK_YELLOW: attack_yellow_next = pwdata[0];
                dgafp_pkg::REG_NO_GOAL_CODE:  no_goal_next = signed'(pwdata[FW-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_yellow_reg <= 1'b1;
            no_goal_reg       <= dgafp_pkg::NO_GOAL_RESET;
        end else begin
            attack_yellow_reg <= attack_yellow_next;
            no_goal_reg       <= no_goal_next;
        end
    end

    dgafp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .f_valid   (f_valid),
        .f_ready   (f_ready),
        .f_item    (f_item)
    );

    dgafp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    dgafp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_attack_yellow (attack_yellow_reg),
        .cfg_no_goal_code  (no_goal_reg),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_colour    (m_frame_colour),
        .m_raw_value       (m_raw_value),
        .m_held_yellow     (m_held_yellow),
        .m_held_blue       (m_held_blue),
        .m_pair_ready      (m_pair_ready),
        .m_attack_angle    (m_attack_angle),
        .m_defense_angle   (m_defense_angle)
    );

    assign q_pop = q_valid && q_ready;

`ifndef SYNTHESIS
    // a stalled result beat blocks the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_pop)
        else $error("parser advanced while result beat stalled");

    // an accepted byte lands in the classify register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> f_valid)
        else $error("accepted byte lost at front");

    // angles are zero unless a pair completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pair_ready |-> m_attack_angle == '0 && m_defense_angle == '0)
        else $error("angles reported without pair");
`endif

endmodule
